### rtl/sb2da_pkg.sv
// sb2da_pkg: shared types and constants for the signed binary to decimal ascii block
// no dependencies
`timescale 1ns / 1ps

package sb2da_pkg;

  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned SYMBOL_W = 6;

  localparam logic [SYMBOL_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 6'd45;

  // double dabble adjust: digits of five or more get three added before the shift
  localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGS
  } state_e;

  // per-cycle command to every digit cell
  typedef struct packed {
    logic clear;
    logic dabble;
    logic move;
  } cell_ctrl_t;

endpackage

### rtl/sb2da_cell.sv
// sb2da_cell: one bcd digit of the conversion row
// clears, shifts one bit in from its lower neighbor (double dabble), or takes its whole digit
// depends on sb2da_pkg
`timescale 1ns / 1ps

module sb2da_cell import sb2da_pkg::*; (
  input  logic               clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  logic               carry_i,
  input  logic [DIGIT_W-1:0] digit_i,
  output logic [DIGIT_W-1:0] digit_o,
  output logic               carry_o
);

  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic [DIGIT_W-1:0] adj;

  assign adj     = (digit_q >= DABBLE_MIN) ? (digit_q + DABBLE_ADD) : digit_q;
  assign carry_o = adj[DIGIT_W-1];
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[DIGIT_W-2:0], carry_i};
    end else if (ctrl_i.move) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

### rtl/signed_binary_to_decimal_ascii.sv
// signed binary to decimal ascii: one character per output beat, sign first, msd first
// operation: the row of bcd cells takes one magnitude bit per cycle, then leading zeros among
//   the NDIG digit positions are skipped and the rest emitted serially, one character per cycle
//   while the output is taken; a new input is accepted only once the last character is loaded
// reset: rst_ni clears the state machine and output valid; digit cells hold no reset
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii import sb2da_pkg::*; #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [63:0]  value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SYMBOL_W-1:0] symbol_o,
  output logic                last_o
);

  // decimal digits of 2^(VALUE_BITS-1)
  localparam int unsigned NDIG  = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);
  localparam int unsigned REM_W = $clog2(NDIG + 1);

  state_e state_q, state_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic                  ovalid_q, ovalid_d;
  logic [SYMBOL_W-1:0]   symbol_q, symbol_d;
  logic                  last_q, last_d;

  logic [VALUE_BITS-1:0] in_bits;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;
  logic                  in_fire;
  logic                  slot_free;
  logic                  out_load;
  cell_ctrl_t            ctrl;

  logic [DIGIT_W-1:0] dig   [NDIG];
  logic               carry [NDIG];
  logic [DIGIT_W-1:0] top_dig;

  assign in_bits = value_i[VALUE_BITS-1:0];
  assign in_neg  = in_bits[VALUE_BITS-1];
  // most negative value maps to 2^(VALUE_BITS-1), which still fits unsigned
  assign in_mag  = in_neg ? (~in_bits + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : in_bits;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !ovalid_q || out_ready_i;
  assign top_dig    = dig[NDIG-1];

  for (genvar k = 0; k < NDIG; k++) begin : g_cell
    logic               c_in;
    logic [DIGIT_W-1:0] d_in;
    if (k == 0) begin : g_first
      assign c_in = mag_q[VALUE_BITS-1];
      assign d_in = '0;
    end else begin : g_rest
      assign c_in = carry[k-1];
      assign d_in = dig[k-1];
    end
    sb2da_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .carry_i (c_in),
      .digit_i (d_in),
      .digit_o (dig[k]),
      .carry_o (carry[k])
    );
  end

  always_comb begin
    state_d  = state_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    ctrl     = '0;
    out_load = 1'b0;
    symbol_d = symbol_q;
    last_d   = last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          mag_d      = in_mag;
          neg_d      = in_neg;
          cnt_d      = CNT_W'(VALUE_BITS);
          ctrl.clear = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.dabble = 1'b1;
        mag_d       = {mag_q[VALUE_BITS-2:0], 1'b0};
        cnt_d       = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          rem_d   = REM_W'(NDIG);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keeping at least one digit
        if (top_dig == '0 && rem_q != REM_W'(1)) begin
          ctrl.move = 1'b1;
          rem_d     = rem_q - 1'b1;
        end else begin
          state_d = neg_q ? ST_SIGN : ST_DIGS;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_load = 1'b1;
          symbol_d = CHAR_MINUS;
          last_d   = 1'b0;
          state_d  = ST_DIGS;
        end
      end
      ST_DIGS: begin
        if (slot_free) begin
          out_load  = 1'b1;
          symbol_d  = CHAR_ZERO + {{(SYMBOL_W-DIGIT_W){1'b0}}, top_dig};
          last_d    = (rem_q == REM_W'(1));
          ctrl.move = 1'b1;
          rem_d     = rem_q - 1'b1;
          if (rem_q == REM_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (out_load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    neg_q    <= neg_d;
    cnt_q    <= cnt_d;
    rem_q    <= rem_d;
    symbol_q <= symbol_d;
    last_q   <= last_d;
  end

  assign out_valid_o = ovalid_q;
  assign symbol_o    = symbol_q;
  assign last_o      = last_q;

`ifndef NO_ASSERTIONS
  a_accept_starts_conv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_CONV) && (cnt_q == CNT_W'(VALUE_BITS)))
    else $error("conversion did not start after an input beat");

  a_last_ends_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_d) |=> (state_q == ST_IDLE))
    else $error("item not finished after its last character");

  a_symbol_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && symbol_o != CHAR_MINUS) |->
      (symbol_o >= CHAR_ZERO && symbol_o <= CHAR_ZERO + 6'd9))
    else $error("emitted character is not a decimal digit");

  a_rem_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SKIP || state_q == ST_SIGN || state_q == ST_DIGS) |-> (rem_q != '0))
    else $error("digit count ran out during emission");

  a_minus_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && symbol_o == CHAR_MINUS) |-> !last_o)
    else $error("minus sign flagged as last character");
`endif

endmodule
